FILE: rtl/core/config_record_crc32_validator_defines.svh
// ----------------------------------------------------------------------------
// Config record CRC-32 validator: assertion macros
// Shared concurrent assertion forms for the validator RTL.
// ----------------------------------------------------------------------------
`ifndef CONFIG_RECORD_CRC32_VALIDATOR_DEFINES_SVH
`define CONFIG_RECORD_CRC32_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRCV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("crcv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("crcv assertion failed");

`endif

FILE: rtl/core/crcv_pkg.sv
// ----------------------------------------------------------------------------
// crcv_pkg
// Types, codes and constants of the config record CRC-32 validator.
// ----------------------------------------------------------------------------
package crcv_pkg;

  localparam int unsigned MAX_RECORD_BYTES = 4096;

  localparam int unsigned OFS_W  = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;

  // Register reset values
  localparam logic [BYTE_W-1:0] EXP_VERSION_RST  = 8'd1;
  localparam logic [OFS_W-1:0]  SUM_OFS_RST      = 12'd4;
  localparam logic [OFS_W-1:0]  CNT_OFS_RST      = 12'd8;
  localparam logic [BYTE_W-1:0] EXP_CHANNELS_RST = 8'd4;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_VERSION  = 2'd1,
    STATUS_CHECKSUM = 2'd2,
    STATUS_COUNT    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_EXP_VERSION  = 2'd0,
    REG_SUM_OFS      = 2'd1,
    REG_CNT_OFS      = 2'd2,
    REG_EXP_CHANNELS = 2'd3
  } reg_e;

  // One byte of reflected CRC-32, bit steps unrolled into an XOR network
  function automatic logic [WORD_W-1:0] crc_byte(logic [WORD_W-1:0] crc,
                                                 logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {WORD_W{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/config_record_crc32_validator.sv
// ----------------------------------------------------------------------------
// config_record_crc32_validator
// Streams a settings record byte by byte, checks version, CRC-32 and count.
// ----------------------------------------------------------------------------
// Feed the record one byte per beat in address order and mark the final byte
// with last_byte_i. The block runs a reflected CRC-32 (poly 0xEDB88320, init
// all ones, final inversion) over every byte except the four-byte stored
// checksum window at checksum_offset, captures the version byte at offset 0,
// the little-endian stored checksum and the little-endian 32-bit channel
// count at count_offset. The final byte produces one result beat carrying the
// CRC, the stored checksum and a status (version mismatch first, then
// checksum mismatch, then count mismatch, else ok); all record state then
// returns to reset for the next record, while the registers keep their value.
// Throughput is one byte per clock unless a final byte waits on a stalled
// result register: each byte passes an input register, then the byte-wide
// CRC XOR network plus field capture; the final byte's result lands in the
// result register. The byte index saturates at MAX_RECORD_BYTES-1; later
// bytes all count at that index. Bytes of a field that never arrive read as
// zero. Write the registers only while no record is in flight.
// ----------------------------------------------------------------------------
`include "config_record_crc32_validator_defines.svh"

module config_record_crc32_validator #(
  parameter int unsigned MAX_RECORD_BYTES = crcv_pkg::MAX_RECORD_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Record byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,

  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] crc_result_o,
  output logic [31:0] stored_crc_o,
  output logic [1:0]  status_o,

  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = $clog2(MAX_RECORD_BYTES);
  localparam int unsigned CMP_W = ((IDX_W > crcv_pkg::OFS_W) ? IDX_W : crcv_pkg::OFS_W) + 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_RECORD_BYTES - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  exp_version_q;
  logic [11:0] sum_ofs_q;
  logic [11:0] cnt_ofs_q;
  logic [7:0]  exp_channels_q;
  logic        cfg_wr;
  crcv_pkg::reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = crcv_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q  <= crcv_pkg::EXP_VERSION_RST;
      sum_ofs_q      <= crcv_pkg::SUM_OFS_RST;
      cnt_ofs_q      <= crcv_pkg::CNT_OFS_RST;
      exp_channels_q <= crcv_pkg::EXP_CHANNELS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        crcv_pkg::REG_EXP_VERSION:  exp_version_q  <= pwdata[7:0];
        crcv_pkg::REG_SUM_OFS:      sum_ofs_q      <= pwdata[11:0];
        crcv_pkg::REG_CNT_OFS:      cnt_ofs_q      <= pwdata[11:0];
        crcv_pkg::REG_EXP_CHANNELS: exp_channels_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended
  always_comb begin
    unique case (cfg_sel)
      crcv_pkg::REG_EXP_VERSION:  prdata = {24'd0, exp_version_q};
      crcv_pkg::REG_SUM_OFS:      prdata = {20'd0, sum_ofs_q};
      crcv_pkg::REG_CNT_OFS:      prdata = {20'd0, cnt_ofs_q};
      crcv_pkg::REG_EXP_CHANNELS: prdata = {24'd0, exp_channels_q};
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       in_fire;
  logic       out_free;
  logic       s1_fire;

  // A non-last beat never needs the result register; a last beat waits for it
  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Record state and per-byte update
  // --------------------------------------------------------------------------
  logic [31:0]      crc_q, crc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [31:0]      sum_q, sum_d;
  logic [7:0]       ver_q, ver_d;
  logic [31:0]      cnt_q, cnt_d;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] sum_diff, cnt_diff;
  logic             sum_hit, cnt_hit;
  logic [31:0]      crc_upd, result;
  crcv_pkg::status_e status;

  always_comb begin
    pos_ext  = CMP_W'(idx_q);
    sum_diff = pos_ext - CMP_W'(sum_ofs_q);
    cnt_diff = pos_ext - CMP_W'(cnt_ofs_q);
    sum_hit  = (pos_ext >= CMP_W'(sum_ofs_q)) && (sum_diff < CMP_W'(4));
    cnt_hit  = (pos_ext >= CMP_W'(cnt_ofs_q)) && (cnt_diff < CMP_W'(4));

    // Bytes in the checksum window stay out of the CRC
    crc_upd = sum_hit ? crc_q : crcv_pkg::crc_byte(crc_q, s1_byte_q);
    ver_d   = (idx_q == '0) ? s1_byte_q : ver_q;

    sum_d = sum_q;
    cnt_d = cnt_q;
    for (int k = 0; k < 4; k++) begin
      if (sum_hit && (sum_diff[1:0] == 2'(k))) begin
        sum_d[k*8 +: 8] = s1_byte_q;
      end
      if (cnt_hit && (cnt_diff[1:0] == 2'(k))) begin
        cnt_d[k*8 +: 8] = s1_byte_q;
      end
    end

    result = ~crc_upd;
    if (ver_d != exp_version_q) begin
      status = crcv_pkg::STATUS_VERSION;
    end else if (result != sum_d) begin
      status = crcv_pkg::STATUS_CHECKSUM;
    end else if (cnt_d != {24'd0, exp_channels_q}) begin
      status = crcv_pkg::STATUS_COUNT;
    end else begin
      status = crcv_pkg::STATUS_OK;
    end

    // Saturate the index at the last record position
    idx_d = (idx_q == IDX_MAX) ? idx_q : idx_q + 1'b1;
    crc_d = crc_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= crcv_pkg::CRC_INIT;
      idx_q <= '0;
      sum_q <= '0;
      ver_q <= '0;
      cnt_q <= '0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        // Drop the record state once the result is loaded into the result register
        crc_q <= crcv_pkg::CRC_INIT;
        idx_q <= '0;
        sum_q <= '0;
        ver_q <= '0;
        cnt_q <= '0;
      end else begin
        crc_q <= crc_d;
        idx_q <= idx_d;
        sum_q <= sum_d;
        ver_q <= ver_d;
        cnt_q <= cnt_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic out_valid_q, out_valid_d;
  logic out_load;

  assign out_load = s1_fire && s1_last_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      crc_result_o <= result;
      stored_crc_o <= sum_d;
      status_o     <= status;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CRCV_ASSERT_NOW(a_stall_needs_beat, clk_i, rst_ni, in_stall_o, s1_valid_q && s1_last_q)
  `CRCV_ASSERT_NOW(a_load_when_free, clk_i, rst_ni, out_load, out_free)
  `CRCV_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, out_load,
                    (idx_q == '0) && (crc_q == crcv_pkg::CRC_INIT))
  `CRCV_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, s1_fire && !s1_last_q && (idx_q != IDX_MAX),
                    idx_q == $past(idx_q) + 1'b1)

endmodule
